>>> rtl/rgb2hls_pkg.sv
// ----------------------------------------------------------------------------
// rgb2hls_pkg
// types, widths and the divide cell payload of the rgb to hls converter
// ----------------------------------------------------------------------------
`default_nettype none

package rgb2hls_pkg;

    localparam int CH_W      = 8;              // color channel width
    localparam int Q_W       = 8;              // quotient width of both divides
    localparam int NUM_CELLS = Q_W;            // one quotient bit per cell
    localparam int SAT_DIV_W = CH_W + Q_W - 1; // divisor aligned to quotient msb
    localparam int SAT_REM_W = SAT_DIV_W + 1;
    localparam int D6_W      = CH_W + 3;       // 6*d
    localparam int HUE_DIV_W = D6_W + Q_W - 1;
    localparam int HUE_REM_W = HUE_DIV_W + 1;

    // payload carried from cell to cell
    typedef struct packed {
        logic [SAT_REM_W-1:0] sat_rem;
        logic [SAT_DIV_W-1:0] sat_div;
        logic [Q_W-1:0]       sat_q;
        logic [HUE_REM_W-1:0] hue_rem;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [Q_W-1:0]       hue_q;
        logic [CH_W-1:0]      light;
        logic                 frame_end;
    } t_cell;

endpackage : rgb2hls_pkg

`default_nettype wire

>>> rtl/rgb2hls_if.sv
// ----------------------------------------------------------------------------
// rgb2hls_if
// valid/ready channels for rgb pixels in and hls pixels out
// ----------------------------------------------------------------------------
`default_nettype none

interface rgb2hls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;

    modport source (output valid, red, green, blue, frame_end, input ready);
    modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface : rgb2hls_in_if

interface rgb2hls_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] lightness;
    logic [7:0] saturation;
    logic       frame_end_out;

    modport source (output valid, hue, lightness, saturation, frame_end_out, input ready);
    modport sink   (input valid, hue, lightness, saturation, frame_end_out, output ready);
endinterface : rgb2hls_out_if

`default_nettype wire

>>> rtl/rgb_to_hls_pixel_convert_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hls_pixel_convert_unit
// 8-bit rgb pixel to 8-bit hue, lightness and saturation, exact truncation
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | item payload
//  i_rgb   | in  | valid/ready          | red, green, blue, frame_end
//  o_hls   | out | valid/ready          | hue, lightness, saturation, frame_end_out
//
//  one item per clock sustained while o_hls.ready holds; an item passes one prep stage
//  and then eight divide cells to o_hls.valid, one quotient bit per cell
//  each stage holds its item until the next stage takes it; empty stages close up,
//  so items keep entering while a finished result waits at the output
//  synchronous active-low reset clears the valid bits only
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hls_pixel_convert_unit
    import rgb2hls_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rgb2hls_in_if.sink    i_rgb,
    rgb2hls_out_if.source o_hls
);

    // stage 0 is prep, stages 1..NUM_CELLS are divide cells
    t_cell stage_data  [0:NUM_CELLS];
    logic  stage_valid [0:NUM_CELLS];
    logic  stage_en    [0:NUM_CELLS+1];

    // output stage advances when the consumer takes the item
    assign stage_en[NUM_CELLS+1] = o_hls.ready;

    rgb2hls_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_rgb.valid),
        .i_red       (i_rgb.red),
        .i_green     (i_rgb.green),
        .i_blue      (i_rgb.blue),
        .i_frame_end (i_rgb.frame_end),
        .i_down_en   (stage_en[1]),
        .o_en        (stage_en[0]),
        .o_valid     (stage_valid[0]),
        .o_data      (stage_data[0])
    );

    // row of divide cells, each resolving the next lower quotient bit
    for (genvar k = 1; k <= NUM_CELLS; k++) begin : g_cell
        rgb2hls_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (stage_valid[k-1]),
            .i_data    (stage_data[k-1]),
            .i_down_en (stage_en[k+1]),
            .o_en      (stage_en[k]),
            .o_valid   (stage_valid[k]),
            .o_data    (stage_data[k])
        );
    end

    assign i_rgb.ready = stage_en[0];

    // last cell register is the output register
    assign o_hls.valid         = stage_valid[NUM_CELLS];
    assign o_hls.hue           = stage_data[NUM_CELLS].hue_q;
    assign o_hls.saturation    = stage_data[NUM_CELLS].sat_q;
    assign o_hls.lightness     = stage_data[NUM_CELLS].light;
    assign o_hls.frame_end_out = stage_data[NUM_CELLS].frame_end;

endmodule : rgb_to_hls_pixel_convert_unit

`default_nettype wire

>>> rtl/rgb2hls_prep.sv
// ----------------------------------------------------------------------------
// rgb2hls_prep
// first stage: max/min, lightness, dividends and aligned divisors
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2hls_prep
    import rgb2hls_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [CH_W-1:0] i_red,
    input  wire logic [CH_W-1:0] i_green,
    input  wire logic [CH_W-1:0] i_blue,
    input  wire logic            i_frame_end,
    input  wire logic            i_down_en,
    output logic                 o_en,
    output logic                 o_valid,
    output t_cell                o_data
);

    logic              r_valid;
    t_cell             r_data;
    t_cell             n_data;
    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   mn;
    logic [CH_W-1:0]   d;
    logic [CH_W:0]     t;
    logic [CH_W-1:0]   den;
    logic [D6_W-1:0]   d6;
    logic [D6_W:0]     num;      // signed sector numerator, two's complement
    logic [D6_W:0]     num_adj;
    logic [D6_W-1:0]   num_pos;
    logic              grey;

    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        if (i_blue > mx) begin
            mx = i_blue;
        end
        mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue < mn) begin
            mn = i_blue;
        end
        d    = mx - mn;
        t    = {1'b0, mx} + {1'b0, mn};
        grey = (d == '0);
        // t < 255 gives den = t, else 510 - t; both fit in a byte
        if (t < (CH_W+1)'(255)) begin
            den = t[CH_W-1:0];
        end else begin
            den = CH_W'((CH_W+1)'(510) - t);
        end
        d6 = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};

        // sector numerator, red wins ties, then green
        if (i_red == mx) begin
            num = {4'b0000, i_green} - {4'b0000, i_blue};
        end else if (i_green == mx) begin
            num = {3'b000, d, 1'b0} + {4'b0000, i_blue} - {4'b0000, i_red};
        end else begin
            num = {2'b00, d, 2'b00} + {4'b0000, i_red} - {4'b0000, i_green};
        end
        num_adj = num[D6_W] ? (num + {1'b0, d6}) : num;
        num_pos = num_adj[D6_W-1:0];

        n_data.sat_rem   = {d, {CH_W{1'b0}}} - {{CH_W{1'b0}}, d};           // 255*d
        n_data.sat_div   = grey ? '1 : {den, {(Q_W-1){1'b0}}};
        n_data.sat_q     = '0;
        n_data.hue_rem   = {num_pos, {CH_W{1'b0}}} - {{CH_W{1'b0}}, num_pos}; // 255*num
        n_data.hue_div   = grey ? '1 : {d6, {(Q_W-1){1'b0}}};
        n_data.hue_q     = '0;
        n_data.light     = t[CH_W:1];
        n_data.frame_end = i_frame_end;
    end

    assign o_en = !r_valid || i_down_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule : rgb2hls_prep

`default_nettype wire

>>> rtl/rgb2hls_cell.sv
// ----------------------------------------------------------------------------
// rgb2hls_cell
// one restoring divide step for saturation and hue, one quotient bit each
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2hls_cell
    import rgb2hls_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_cell i_data,
    input  wire logic  i_down_en,
    output logic       o_en,
    output logic       o_valid,
    output t_cell      o_data
);

    logic                 r_valid;
    t_cell                r_data;
    t_cell                n_data;
    logic                 sat_ge;
    logic                 hue_ge;
    logic [SAT_REM_W-1:0] sat_sub;
    logic [HUE_REM_W-1:0] hue_sub;

    always_comb begin
        sat_ge  = i_data.sat_rem >= {1'b0, i_data.sat_div};
        sat_sub = sat_ge ? (i_data.sat_rem - {1'b0, i_data.sat_div}) : i_data.sat_rem;
        hue_ge  = i_data.hue_rem >= {1'b0, i_data.hue_div};
        hue_sub = hue_ge ? (i_data.hue_rem - {1'b0, i_data.hue_div}) : i_data.hue_rem;

        n_data         = i_data;
        n_data.sat_rem = {sat_sub[SAT_REM_W-2:0], 1'b0};
        n_data.sat_q   = {i_data.sat_q[Q_W-2:0], sat_ge};
        n_data.hue_rem = {hue_sub[HUE_REM_W-2:0], 1'b0};
        n_data.hue_q   = {i_data.hue_q[Q_W-2:0], hue_ge};
    end

    assign o_en = !r_valid || i_down_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule : rgb2hls_cell

`default_nettype wire

>>> rtl/rgb2hls_checker.sv
// ----------------------------------------------------------------------------
// rgb2hls_checker
// port-level checks of the rgb to hls converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2hls_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_hue,
    input wire logic [7:0] i_lightness,
    input wire logic [7:0] i_saturation,
    input wire logic       i_frame_end_out
);

    logic [3:0] r_count;
    logic [3:0] n_count;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_count = r_count;
        if (in_acc && !out_acc) begin
            n_count = r_count + 4'd1;
        end else if (!in_acc && out_acc) begin
            n_count = r_count - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hue)
            && $stable(i_lightness) && $stable(i_saturation) && $stable(i_frame_end_out))
        else $error("result changed while stalled");

    // no more items in flight than pipeline stages
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 4'd9)
        else $error("too many items in flight");

    // a result only for an accepted item
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == 4'd0 |-> !i_out_valid)
        else $error("result without an item");

    // a result with nonzero hue always has nonzero saturation
    a_hue_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hue != 8'd0 |-> i_saturation != 8'd0)
        else $error("hue without saturation");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("valid result after reset");

endmodule : rgb2hls_checker

bind rgb_to_hls_pixel_convert_unit rgb2hls_checker u_rgb2hls_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_rgb.valid),
    .i_in_ready      (i_rgb.ready),
    .i_out_valid     (o_hls.valid),
    .i_out_ready     (o_hls.ready),
    .i_hue           (o_hls.hue),
    .i_lightness     (o_hls.lightness),
    .i_saturation    (o_hls.saturation),
    .i_frame_end_out (o_hls.frame_end_out)
);

`default_nettype wire

>>> sim/rgb_to_hls_pixel_convert_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hls_pixel_convert_unit_tb
// self-checking bench for the rgb to hls pixel converter: a queued driver
// offers rgb items with random gaps, a monitor takes hls items under random
// back-pressure, and every result is checked against an in-bench hue,
// lightness and saturation calculation done in exact integer arithmetic
// ----------------------------------------------------------------------------

module rgb_to_hls_pixel_convert_unit_tb;
    import rgb2hls_pkg::*;

    // one pixel waiting to be offered, with its pacing flags
    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
        bit              no_gap;      // send back to back, no idle after it
        bit              drain_first; // hold it until every result is back
    } t_rgb_px;

    // one converted pixel as it leaves the block
    typedef struct packed {
        logic [CH_W-1:0] hue;
        logic [CH_W-1:0] lightness;
        logic [CH_W-1:0] saturation;
        logic            frame_end;
    } t_hls_px;

    localparam int RESET_CYCLES   = 8;
    localparam int PIPE_SETTLE    = 20;          // margin over the prep stage and the eight divide cells
    localparam int HOLD_AT_RESULT = 500;         // long output stall starts here
    localparam int HOLD_CYCLES    = 200;
    localparam int RANDOM_ITEMS   = 1425;
    localparam int MAX_REPORTS    = 10;

    logic i_clk;
    logic i_rst_n;

    rgb2hls_in_if  pix_in ();
    rgb2hls_out_if pix_out ();

    rgb_to_hls_pixel_convert_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rgb   (pix_in),
        .o_hls   (pix_out)
    );

    t_rgb_px     rgb_backlog[$];   // items not yet offered
    t_hls_px     hls_due[$];       // predicted results, oldest first
    int unsigned pix_taken   = 0;  // items accepted at the input
    int unsigned hls_seen    = 0;  // results matched against a prediction
    int unsigned err_cnt     = 0;
    int unsigned send_idle   = 0;
    int unsigned take_idle   = 0;
    int unsigned hold_left   = 0;
    bit          hold_done   = 0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin : clk_gen
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor: exact truncated hls of one rgb pixel
    // ------------------------------------------------------------------------
    function automatic t_hls_px rgb_to_hls(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                           input logic [CH_W-1:0] b, input logic fe);
        int      peak;
        int      floor_v;
        int      span;
        int      total;
        int      den;
        int      sector;
        t_hls_px res;
        peak    = int'(r);
        floor_v = int'(r);
        if (int'(g) > peak) peak = int'(g);
        if (int'(b) > peak) peak = int'(b);
        if (int'(g) < floor_v) floor_v = int'(g);
        if (int'(b) < floor_v) floor_v = int'(b);
        span  = peak - floor_v;
        total = peak + floor_v;
        res.lightness  = CH_W'(total >> 1);
        res.hue        = '0;
        res.saturation = '0;
        res.frame_end  = fe;
        // grey pixels keep hue and saturation at zero
        if (span != 0) begin
            den = (total < 255) ? total : 510 - total;
            res.saturation = CH_W'((255 * span) / den);
            // sector priority on ties: red, then green, then blue
            if (int'(r) == peak) begin
                sector = int'(g) - int'(b);
            end else if (int'(g) == peak) begin
                sector = 2 * span + int'(b) - int'(r);
            end else begin
                sector = 4 * span + int'(r) - int'(g);
            end
            if (sector < 0) sector += 6 * span;
            res.hue = CH_W'((255 * sector) / (6 * span));
        end
        return res;
    endfunction

    // mostly short idles, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                               input logic [CH_W-1:0] b, input logic fe,
                               input bit calm, input bit drain);
        t_rgb_px px;
        px.red         = r;
        px.green       = g;
        px.blue        = b;
        px.frame_end   = fe;
        px.no_gap      = calm;
        px.drain_first = drain;
        rgb_backlog.push_back(px);
    endtask

    // ------------------------------------------------------------------------
    // input driver: offers backlog items, records a prediction per accepted item
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : rgb_driver
        bit      fired;
        t_rgb_px px;
        fired = 1'b0;
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else begin
            if (pix_in.valid && pix_in.ready) begin
                fired = 1'b1;
                hls_due.push_back(rgb_to_hls(pix_in.red, pix_in.green, pix_in.blue,
                                             pix_in.frame_end));
                pix_taken <= pix_taken + 1;
            end
            // the channel is free once the held item went through or none is up
            if (!pix_in.valid || fired) begin
                if (send_idle != 0) begin
                    send_idle    <= send_idle - 1;
                    pix_in.valid <= 1'b0;
                end else if (rgb_backlog.size() != 0 &&
                             !(rgb_backlog[0].drain_first &&
                               pix_taken + fired != hls_seen)) begin
                    px = rgb_backlog.pop_front();
                    pix_in.valid     <= 1'b1;
                    pix_in.red       <= px.red;
                    pix_in.green     <= px.green;
                    pix_in.blue      <= px.blue;
                    pix_in.frame_end <= px.frame_end;
                    send_idle        <= px.no_gap ? 0 : idle_len();
                end else begin
                    // nothing to send, or pausing until the pipe has emptied
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // long output stall, counted here so the block backs up into its input
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : out_hold
        if (i_rst_n) begin
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (!hold_done && hls_seen >= HOLD_AT_RESULT) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output monitor: checks each result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : hls_monitor
        t_hls_px want;
        t_hls_px got;
        if (i_rst_n) begin
            if (pix_out.valid && pix_out.ready) begin
                got.hue        = pix_out.hue;
                got.lightness  = pix_out.lightness;
                got.saturation = pix_out.saturation;
                got.frame_end  = pix_out.frame_end_out;
                if (hls_due.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: result with no item pending: h=%0d l=%0d s=%0d fe=%0b",
                                 $realtime, got.hue, got.lightness, got.saturation,
                                 got.frame_end);
                end else begin
                    want = hls_due.pop_front();
                    hls_seen <= hls_seen + 1;
                    if (got.hue !== want.hue || got.lightness !== want.lightness ||
                        got.saturation !== want.saturation ||
                        got.frame_end !== want.frame_end) begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("%0t: result %0d exp h=%0d l=%0d s=%0d fe=%0b",
                                     $realtime, hls_seen, want.hue, want.lightness,
                                     want.saturation, want.frame_end);
                            $display("%0t: result %0d got h=%0d l=%0d s=%0d fe=%0b",
                                     $realtime, hls_seen, got.hue, got.lightness,
                                     got.saturation, got.frame_end);
                        end
                    end
                end
            end
            // ready: long hold, then random stalls, with calm stretches always ready
            if (hold_left != 0) begin
                pix_out.ready <= 1'b0;
            end else if (take_idle != 0) begin
                take_idle     <= take_idle - 1;
                pix_out.ready <= 1'b0;
            end else begin
                pix_out.ready <= 1'b1;
                if ((hls_seen / 256) % 4 != 3 && $urandom_range(0, 4) == 0)
                    take_idle <= idle_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [CH_W-1:0] base;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        int unsigned     kind;
        bit              calm;

        i_rst_n          = 1'b0;
        pix_in.valid     = 1'b0;
        pix_in.red       = '0;
        pix_in.green     = '0;
        pix_in.blue      = '0;
        pix_in.frame_end = 1'b0;
        pix_out.ready    = 1'b0;

        // directed: greys, primaries, tie priorities, saturation branch edges
        queue_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0); // black
        queue_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0); // white, frame end
        queue_pixel(8'd128, 8'd128, 8'd128, 1'b0, 1'b0, 1'b0); // mid grey
        queue_pixel(8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 1'b0); // red
        queue_pixel(8'd0,   8'd255, 8'd0,   1'b0, 1'b1, 1'b0); // green
        queue_pixel(8'd0,   8'd0,   8'd255, 1'b0, 1'b1, 1'b0); // blue
        queue_pixel(8'd255, 8'd255, 8'd0,   1'b0, 1'b0, 1'b0); // red/green tie
        queue_pixel(8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 1'b0); // green/blue tie
        queue_pixel(8'd255, 8'd0,   8'd255, 1'b0, 1'b0, 1'b0); // red/blue tie
        queue_pixel(8'd255, 8'd0,   8'd10,  1'b0, 1'b0, 1'b0); // red sector wraps
        queue_pixel(8'd254, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0); // sum just below 255
        queue_pixel(8'd200, 8'd55,  8'd100, 1'b1, 1'b0, 1'b0); // sum exactly 255
        queue_pixel(8'd1,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0); // smallest spread
        queue_pixel(8'd0,   8'd1,   8'd1,   1'b0, 1'b0, 1'b0);
        queue_pixel(8'd255, 8'd254, 8'd254, 1'b0, 1'b0, 1'b0); // near white
        queue_pixel(8'd254, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
        queue_pixel(8'd10,  8'd200, 8'd30,  1'b0, 1'b0, 1'b0); // green sector
        queue_pixel(8'd90,  8'd20,  8'd230, 1'b0, 1'b0, 1'b0); // blue sector r > g
        queue_pixel(8'd20,  8'd90,  8'd230, 1'b0, 1'b0, 1'b0); // blue sector r < g
        queue_pixel(8'd170, 8'd85,  8'd85,  1'b0, 1'b0, 1'b0);
        queue_pixel(8'd127, 8'd128, 8'd0,   1'b1, 1'b0, 1'b0);
        queue_pixel(8'd255, 8'd128, 8'd1,   1'b0, 1'b0, 1'b0);

        // random: uniform pixels, near greys, ties and extremes
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            kind = $urandom_range(0, 9);
            base = CH_W'($urandom);
            r    = CH_W'($urandom);
            g    = CH_W'($urandom);
            b    = CH_W'($urandom);
            if (kind == 5 || kind == 6) begin
                r = base + CH_W'($urandom_range(0, 3));
                g = base + CH_W'($urandom_range(0, 3));
                b = base + CH_W'($urandom_range(0, 3));
            end else if (kind == 7) begin
                case ($urandom_range(0, 2))
                    0: g = r;
                    1: b = g;
                    default: b = r;
                endcase
            end else if (kind == 8) begin
                r = ($urandom_range(0, 2) == 0) ? r : ($urandom_range(0, 1) ? 8'd255 : 8'd0);
                g = ($urandom_range(0, 2) == 0) ? g : ($urandom_range(0, 1) ? 8'd255 : 8'd0);
                b = ($urandom_range(0, 2) == 0) ? b : ($urandom_range(0, 1) ? 8'd255 : 8'd0);
            end else if (kind == 9) begin
                case ($urandom_range(0, 5))
                    0: r = 8'd255;
                    1: g = 8'd255;
                    2: b = 8'd255;
                    3: r = 8'd0;
                    4: g = 8'd0;
                    default: b = 8'd0;
                endcase
            end
            // every fourth block of items goes back to back
            calm = ((k / 128) % 4 == 2);
            // a few items wait for the pipe to drain completely first
            queue_pixel(r, g, b, ($urandom_range(0, 31) == 0), calm,
                        (k == 0 || k == 700 || k == 1200));
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample on the falling edge so the clocked blocks have settled
        while (rgb_backlog.size() != 0 || pix_in.valid || hls_due.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);

        if (err_cnt == 0 && hls_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // watchdog, far beyond the slowest legal run
    // ------------------------------------------------------------------------
    initial begin : watchdog
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule : rgb_to_hls_pixel_convert_unit_tb

>>> filelist.f
rtl/rgb2hls_pkg.sv
rtl/rgb2hls_if.sv
rtl/rgb2hls_prep.sv
rtl/rgb2hls_cell.sv
rtl/rgb_to_hls_pixel_convert_unit.sv
rtl/rgb2hls_checker.sv
sim/rgb_to_hls_pixel_convert_unit_tb.sv
